>>> rtl/gnp_pkg.sv
// ----------------------------------------------------------------------------
// gnp_pkg
// Shared constants, codes and types of the graph neighbor pruner.
// ----------------------------------------------------------------------------
package gnp_pkg;

  localparam int MAX_CANDS = 64;
  localparam int VEC_DIM   = 128;

  localparam int SLOT_W  = $clog2(MAX_CANDS);
  localparam int CNT_W   = SLOT_W + 1;
  localparam int DIM_W   = $clog2(VEC_DIM);
  localparam int CVEC_AW = SLOT_W + DIM_W;
  localparam int VAL_W   = 16;
  localparam int MAG_W   = 16;
  localparam int SQ_W    = 2 * MAG_W;
  localparam int DIST_W  = 42;
  localparam int ID_W    = 32;
  localparam int DEG_W   = 6;

  // command codes
  localparam logic [1:0] CMD_NODE  = 2'd0;
  localparam logic [1:0] CMD_CAND  = 2'd1;
  localparam logic [1:0] CMD_PRUNE = 2'd2;

  // register indexes
  localparam logic [1:0] REG_PRUNE_MODE = 2'd0;
  localparam logic [1:0] REG_MIN_DEGREE = 2'd1;
  localparam logic [1:0] REG_MAX_DEGREE = 2'd2;

  // control tag that travels with each element pair through the distance unit
  typedef struct packed {
    logic vld;
    logic first;
    logic last;
  } sq_ctl_t;

  typedef enum logic [1:0] {
    SRC_SLOT,
    SRC_SORT,
    SRC_KEPT
  } emit_src_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_START,
    S_EMPTY,
    S_DIST_ISSUE,
    S_DIST_WAIT,
    S_RK_KEY,
    S_RK_KEY2,
    S_RK_SCAN,
    S_RK_WR,
    S_MR_SEL,
    S_MR_V,
    S_MR_DV,
    S_MR_J,
    S_MR_W,
    S_MR_ISSUE,
    S_MR_WAIT,
    S_FL_SEL,
    S_FL_V,
    S_FL_ID,
    S_FL_K,
    S_FL_K2,
    S_FL_K3,
    S_EM_RD,
    S_EM_SLOT,
    S_EM_OUT
  } state_t;

endpackage

>>> rtl/gnp_sqdist.sv
// ----------------------------------------------------------------------------
// gnp_sqdist
// Pipelined squared L2 distance accumulator: difference, square, accumulate.
// ----------------------------------------------------------------------------
module gnp_sqdist import gnp_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  sq_ctl_t                 ctl,
  input  logic signed [VAL_W-1:0] a,
  input  logic signed [VAL_W-1:0] b,
  output logic                    done,
  output logic [DIST_W-1:0]       acc
);

  sq_ctl_t             ctl1_r, ctl2_r;
  logic [MAG_W-1:0]    mag_r;
  logic [SQ_W-1:0]     sq_r;
  logic [DIST_W-1:0]   acc_r;
  logic                done_r;
  logic signed [VAL_W:0] diff;
  logic [VAL_W:0]      diff_abs;

  always_comb begin
    diff     = (VAL_W+1)'(a) - (VAL_W+1)'(b);
    diff_abs = diff[VAL_W] ? (VAL_W+1)'(-diff) : (VAL_W+1)'(diff);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
      ctl2_r <= '0;
      done_r <= 1'b0;
    end else begin
      ctl1_r <= ctl;
      ctl2_r <= ctl1_r;
      done_r <= ctl2_r.vld & ctl2_r.last;
    end
  end

  always_ff @(posedge clk) begin
    mag_r <= diff_abs[MAG_W-1:0];
    sq_r  <= mag_r * mag_r;
    if (ctl2_r.vld) begin
      // restart on the first element of a vector pair
      acc_r <= ctl2_r.first ? DIST_W'(sq_r) : acc_r + DIST_W'(sq_r);
    end
  end

  assign done = done_r;
  assign acc  = acc_r;

endmodule

>>> rtl/graph_neighbor_pruner_core.sv
// Load transactions are taken only while idle; a prune blocks the input until its last result is queued.
// Prune with n <= max_degree: the results are read out of the candidate id memory.
// Otherwise: distances to the node, ranking, then the max_degree cap by rank (prune_mode 1) or
// MRNG pair checks and fill checks per kept entry, then results; the single distance unit serves all.
// Reset clears registers (prune_mode 0, min_degree 5, max_degree 32) and the candidate count;
// memories are not cleared and no clearing pass runs.
// ----------------------------------------------------------------------------
// graph_neighbor_pruner_core
// Loads a node vector and candidates, then prunes the neighbor list (cap or MRNG).
// ----------------------------------------------------------------------------
module graph_neighbor_pruner_core import gnp_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [1:0]              in_cmd,
  input  logic [SLOT_W-1:0]       in_cand_slot,
  input  logic [ID_W-1:0]         in_cand_id,
  input  logic [DIM_W-1:0]        in_elem_index,
  input  logic signed [VAL_W-1:0] in_elem_value,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [ID_W-1:0]         out_kept_id,
  output logic                    out_is_last,
  output logic                    out_is_empty,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [3:0]              paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  // memories
  logic signed [VAL_W-1:0] node_mem [VEC_DIM];
  logic signed [VAL_W-1:0] cvec_mem [MAX_CANDS*VEC_DIM];
  logic [ID_W-1:0]         cid_mem  [MAX_CANDS];
  logic [DIST_W-1:0]       dist_mem [MAX_CANDS];
  logic [SLOT_W-1:0]       sord_mem [MAX_CANDS];
  logic [SLOT_W-1:0]       klist_mem[MAX_CANDS];

  logic signed [VAL_W-1:0] node_rd, cv0_rd, cv1_rd;
  logic [ID_W-1:0]         cid_rd;
  logic [DIST_W-1:0]       dist_rd;
  logic [SLOT_W-1:0]       sord_rd, klist_rd;

  logic [DIM_W-1:0]   node_ra;
  logic [CVEC_AW-1:0] cv0_ra, cv1_ra;
  logic [SLOT_W-1:0]  cid_ra, dist_ra, sord_ra, klist_ra;

  logic               dist_we, sord_we, klist_we;
  logic [SLOT_W-1:0]  dist_wa, sord_wa, klist_wa;
  logic [SLOT_W-1:0]  sord_wd, klist_wd;

  // registers
  state_t             state_r, state_nxt;
  logic               mode_r;
  logic [DEG_W-1:0]   min_deg_r, max_deg_r;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [CNT_W-1:0]   n_r, n_nxt;
  logic [CNT_W-1:0]   i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic [CNT_W-1:0]   nkept_r, nkept_nxt, total_r, total_nxt, rank_r, rank_nxt;
  logic [DIM_W-1:0]   d_r, d_nxt;
  logic [SLOT_W-1:0]  v_r, v_nxt, w_r, w_nxt, slot_r, slot_nxt, cmp_j_r, cmp_j_nxt;
  logic               cmp_vld_r, cmp_vld_nxt;
  logic [DIST_W-1:0]  kd_r, kd_nxt, dv_r, dv_nxt;
  logic [ID_W-1:0]    kid_r, kid_nxt, vid_r, vid_nxt;
  logic [MAX_CANDS-1:0] flags_r, flags_nxt;
  emit_src_t          src_r, src_nxt;
  sq_ctl_t            issue_ctl_r, issue_ctl_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [ID_W-1:0]    out_id_r, out_id_nxt;
  logic               out_last_r, out_last_nxt, out_empty_r, out_empty_nxt;

  logic               in_acc, cfg_we, out_free, out_load;
  logic               sq_done, pair_mode, inc;
  logic [DIST_W-1:0]  sq_acc;
  logic [DEG_W-1:0]   rmax;
  logic [SLOT_W-1:0]  em_slot;
  logic               d_last;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign pready   = 1'b1;
  assign cfg_we   = psel && penable && pwrite;
  assign out_free = !out_valid_r || !out_stall;
  assign rmax     = (max_deg_r == '0) ? DEG_W'(1) : max_deg_r;
  assign d_last   = (d_r == DIM_W'(VEC_DIM-1));

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= 1'b0;
      min_deg_r <= DEG_W'(5);
      max_deg_r <= DEG_W'(32);
    end else if (cfg_we) begin
      case (paddr[3:2])
        REG_PRUNE_MODE: mode_r    <= pwdata[0];
        REG_MIN_DEGREE: min_deg_r <= pwdata[DEG_W-1:0];
        REG_MAX_DEGREE: max_deg_r <= pwdata[DEG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_PRUNE_MODE: prdata = {31'd0, mode_r};
      REG_MIN_DEGREE: prdata = {{(32-DEG_W){1'b0}}, min_deg_r};
      REG_MAX_DEGREE: prdata = {{(32-DEG_W){1'b0}}, max_deg_r};
      default:        prdata = 32'd0;
    endcase
  end

  // memory ports
  always_ff @(posedge clk) begin
    if (in_acc && in_cmd == CMD_NODE) node_mem[in_elem_index] <= in_elem_value;
    node_rd <= node_mem[node_ra];
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_cmd == CMD_CAND) cvec_mem[{in_cand_slot, in_elem_index}] <= in_elem_value;
    cv0_rd <= cvec_mem[cv0_ra];
    cv1_rd <= cvec_mem[cv1_ra];
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_cmd == CMD_CAND) cid_mem[in_cand_slot] <= in_cand_id;
    cid_rd <= cid_mem[cid_ra];
  end

  always_ff @(posedge clk) begin
    if (dist_we) dist_mem[dist_wa] <= sq_acc;
    dist_rd <= dist_mem[dist_ra];
  end

  always_ff @(posedge clk) begin
    if (sord_we) sord_mem[sord_wa] <= sord_wd;
    sord_rd <= sord_mem[sord_ra];
  end

  always_ff @(posedge clk) begin
    if (klist_we) klist_mem[klist_wa] <= klist_wd;
    klist_rd <= klist_mem[klist_ra];
  end

  // distance unit
  assign pair_mode = (state_r == S_MR_ISSUE) || (state_r == S_MR_WAIT);

  gnp_sqdist u_sqdist (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (issue_ctl_r),
    .a     (cv0_rd),
    .b     (pair_mode ? cv1_rd : node_rd),
    .done  (sq_done),
    .acc   (sq_acc)
  );

  // rank compare: does slot cmp_j order before slot i
  always_comb begin
    inc = cmp_vld_r && ((dist_rd < kd_r) ||
          (dist_rd == kd_r && cid_rd < kid_r) ||
          (dist_rd == kd_r && cid_rd == kid_r && cmp_j_r < i_r[SLOT_W-1:0]));
  end

  always_comb begin
    unique case (src_r)
      SRC_SORT: em_slot = sord_rd;
      SRC_KEPT: em_slot = klist_rd;
      default:  em_slot = k_r[SLOT_W-1:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      flags_r     <= '0;
      cmp_vld_r   <= 1'b0;
      issue_ctl_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      flags_r     <= flags_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      issue_ctl_r <= issue_ctl_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r         <= n_nxt;
    i_r         <= i_nxt;
    j_r         <= j_nxt;
    k_r         <= k_nxt;
    nkept_r     <= nkept_nxt;
    total_r     <= total_nxt;
    rank_r      <= rank_nxt;
    d_r         <= d_nxt;
    v_r         <= v_nxt;
    w_r         <= w_nxt;
    slot_r      <= slot_nxt;
    cmp_j_r     <= cmp_j_nxt;
    kd_r        <= kd_nxt;
    kid_r       <= kid_nxt;
    dv_r        <= dv_nxt;
    vid_r       <= vid_nxt;
    src_r       <= src_nxt;
    out_id_r    <= out_id_nxt;
    out_last_r  <= out_last_nxt;
    out_empty_r <= out_empty_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    n_nxt         = n_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    nkept_nxt     = nkept_r;
    total_nxt     = total_r;
    rank_nxt      = rank_r;
    d_nxt         = d_r;
    v_nxt         = v_r;
    w_nxt         = w_r;
    slot_nxt      = slot_r;
    cmp_j_nxt     = cmp_j_r;
    cmp_vld_nxt   = 1'b0;
    kd_nxt        = kd_r;
    kid_nxt       = kid_r;
    dv_nxt        = dv_r;
    vid_nxt       = vid_r;
    flags_nxt     = flags_r;
    src_nxt       = src_r;
    issue_ctl_nxt = '0;
    out_load      = 1'b0;
    out_id_nxt    = out_id_r;
    out_last_nxt  = out_last_r;
    out_empty_nxt = out_empty_r;
    node_ra       = d_r;
    cv0_ra        = {v_r, d_r};
    cv1_ra        = {w_r, d_r};
    cid_ra        = '0;
    dist_ra       = '0;
    sord_ra       = i_r[SLOT_W-1:0];
    klist_ra      = j_r[SLOT_W-1:0];
    dist_we       = 1'b0;
    dist_wa       = i_r[SLOT_W-1:0];
    sord_we       = 1'b0;
    sord_wa       = '0;
    sord_wd       = i_r[SLOT_W-1:0];
    klist_we      = 1'b0;
    klist_wa      = nkept_r[SLOT_W-1:0];
    klist_wd      = v_r;

    if (cmp_vld_r) rank_nxt = rank_r + CNT_W'(inc);

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_cmd == CMD_CAND) begin
            if ({1'b0, in_cand_slot} + CNT_W'(1) > cnt_r) begin
              cnt_nxt = {1'b0, in_cand_slot} + CNT_W'(1);
            end
          end else if (in_cmd == CMD_PRUNE) begin
            n_nxt     = cnt_r;
            cnt_nxt   = '0;
            state_nxt = S_START;
          end
        end
      end
      S_START: begin
        flags_nxt = '0;
        i_nxt     = '0;
        d_nxt     = '0;
        k_nxt     = '0;
        if (n_r == '0) begin
          state_nxt = S_EMPTY;
        end else if (n_r <= {1'b0, rmax}) begin
          total_nxt = n_r;
          src_nxt   = SRC_SLOT;
          state_nxt = S_EM_RD;
        end else begin
          state_nxt = S_DIST_ISSUE;
        end
      end
      S_EMPTY: begin
        if (out_free) begin
          out_load      = 1'b1;
          out_id_nxt    = '0;
          out_last_nxt  = 1'b1;
          out_empty_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_DIST_ISSUE: begin
        cv0_ra              = {i_r[SLOT_W-1:0], d_r};
        issue_ctl_nxt.vld   = 1'b1;
        issue_ctl_nxt.first = (d_r == '0);
        issue_ctl_nxt.last  = d_last;
        d_nxt               = d_r + DIM_W'(1);
        if (d_last) state_nxt = S_DIST_WAIT;
      end
      S_DIST_WAIT: begin
        if (sq_done) begin
          dist_we = 1'b1;
          d_nxt   = '0;
          if (i_r == n_r - CNT_W'(1)) begin
            i_nxt     = '0;
            state_nxt = S_RK_KEY;
          end else begin
            i_nxt     = i_r + CNT_W'(1);
            state_nxt = S_DIST_ISSUE;
          end
        end
      end
      S_RK_KEY: begin
        dist_ra   = i_r[SLOT_W-1:0];
        cid_ra    = i_r[SLOT_W-1:0];
        state_nxt = S_RK_KEY2;
      end
      S_RK_KEY2: begin
        kd_nxt    = dist_rd;
        kid_nxt   = cid_rd;
        rank_nxt  = '0;
        j_nxt     = '0;
        state_nxt = S_RK_SCAN;
      end
      S_RK_SCAN: begin
        dist_ra     = j_r[SLOT_W-1:0];
        cid_ra      = j_r[SLOT_W-1:0];
        cmp_vld_nxt = 1'b1;
        cmp_j_nxt   = j_r[SLOT_W-1:0];
        j_nxt       = j_r + CNT_W'(1);
        if (j_r == n_r - CNT_W'(1)) state_nxt = S_RK_WR;
      end
      S_RK_WR: begin
        // last compare lands this cycle
        sord_we = 1'b1;
        sord_wa = rank_nxt[SLOT_W-1:0];
        if (i_r == n_r - CNT_W'(1)) begin
          i_nxt     = '0;
          k_nxt     = '0;
          nkept_nxt = '0;
          if (mode_r) begin
            total_nxt = {1'b0, rmax};
            src_nxt   = SRC_SORT;
            state_nxt = S_EM_RD;
          end else begin
            state_nxt = S_MR_SEL;
          end
        end else begin
          i_nxt     = i_r + CNT_W'(1);
          state_nxt = S_RK_KEY;
        end
      end
      S_MR_SEL: begin
        if (i_r == n_r || nkept_r == {1'b0, rmax}) begin
          i_nxt     = '0;
          state_nxt = S_FL_SEL;
        end else begin
          state_nxt = S_MR_V;
        end
      end
      S_MR_V: begin
        v_nxt     = sord_rd;
        dist_ra   = sord_rd;
        state_nxt = S_MR_DV;
      end
      S_MR_DV: begin
        dv_nxt    = dist_rd;
        j_nxt     = '0;
        state_nxt = S_MR_J;
      end
      S_MR_J: begin
        if (j_r == nkept_r) begin
          flags_nxt[v_r] = 1'b1;
          klist_we       = 1'b1;
          nkept_nxt      = nkept_r + CNT_W'(1);
          i_nxt          = i_r + CNT_W'(1);
          state_nxt      = S_MR_SEL;
        end else begin
          state_nxt = S_MR_W;
        end
      end
      S_MR_W: begin
        w_nxt     = klist_rd;
        d_nxt     = '0;
        state_nxt = S_MR_ISSUE;
      end
      S_MR_ISSUE: begin
        issue_ctl_nxt.vld   = 1'b1;
        issue_ctl_nxt.first = (d_r == '0);
        issue_ctl_nxt.last  = d_last;
        d_nxt               = d_r + DIM_W'(1);
        if (d_last) state_nxt = S_MR_WAIT;
      end
      S_MR_WAIT: begin
        if (sq_done) begin
          if (sq_acc < dv_r) begin
            // occluded by a kept neighbor: drop
            i_nxt     = i_r + CNT_W'(1);
            state_nxt = S_MR_SEL;
          end else begin
            j_nxt     = j_r + CNT_W'(1);
            state_nxt = S_MR_J;
          end
        end
      end
      S_FL_SEL: begin
        if (i_r == n_r || nkept_r >= {1'b0, min_deg_r}) begin
          total_nxt = nkept_r;
          src_nxt   = SRC_KEPT;
          k_nxt     = '0;
          state_nxt = S_EM_RD;
        end else begin
          state_nxt = S_FL_V;
        end
      end
      S_FL_V: begin
        v_nxt  = sord_rd;
        cid_ra = sord_rd;
        if (flags_r[sord_rd]) begin
          i_nxt     = i_r + CNT_W'(1);
          state_nxt = S_FL_SEL;
        end else begin
          state_nxt = S_FL_ID;
        end
      end
      S_FL_ID: begin
        vid_nxt   = cid_rd;
        j_nxt     = '0;
        state_nxt = S_FL_K;
      end
      S_FL_K: begin
        if (j_r == nkept_r) begin
          flags_nxt[v_r] = 1'b1;
          klist_we       = 1'b1;
          nkept_nxt      = nkept_r + CNT_W'(1);
          i_nxt          = i_r + CNT_W'(1);
          state_nxt      = S_FL_SEL;
        end else begin
          state_nxt = S_FL_K2;
        end
      end
      S_FL_K2: begin
        cid_ra    = klist_rd;
        state_nxt = S_FL_K3;
      end
      S_FL_K3: begin
        if (cid_rd == vid_r) begin
          // id already kept: skip
          i_nxt     = i_r + CNT_W'(1);
          state_nxt = S_FL_SEL;
        end else begin
          j_nxt     = j_r + CNT_W'(1);
          state_nxt = S_FL_K;
        end
      end
      S_EM_RD: begin
        sord_ra   = k_r[SLOT_W-1:0];
        klist_ra  = k_r[SLOT_W-1:0];
        state_nxt = S_EM_SLOT;
      end
      S_EM_SLOT: begin
        slot_nxt  = em_slot;
        cid_ra    = em_slot;
        state_nxt = S_EM_OUT;
      end
      S_EM_OUT: begin
        // hold the id read while the output register is busy
        cid_ra = slot_r;
        if (out_free) begin
          out_load      = 1'b1;
          out_id_nxt    = cid_rd;
          out_last_nxt  = (k_r == total_r - CNT_W'(1));
          out_empty_nxt = 1'b0;
          k_nxt         = k_r + CNT_W'(1);
          state_nxt     = (k_r == total_r - CNT_W'(1)) ? S_IDLE : S_EM_RD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (out_load)                        out_valid_nxt = 1'b1;
    else if (out_valid_r && !out_stall)  out_valid_nxt = 1'b0;
    else                                 out_valid_nxt = out_valid_r;
  end

  assign out_valid    = out_valid_r;
  assign out_kept_id  = out_id_r;
  assign out_is_last  = out_last_r;
  assign out_is_empty = out_empty_r;

endmodule
